// ----- src/cln_pkg.sv -----
// shared types, constants and init table for the character lcd nibble sequencer
package cln_pkg;

    localparam logic [2:0] OP_INIT     = 3'd0;
    localparam logic [2:0] OP_COMMAND  = 3'd1;
    localparam logic [2:0] OP_CHAR     = 3'd2;
    localparam logic [2:0] OP_NUMBER   = 3'd3;
    localparam logic [2:0] OP_POSITION = 3'd4;

    localparam logic [7:0] ROW0_BASE     = 8'h80;
    localparam logic [7:0] ROW1_BASE     = 8'hC0;
    localparam logic [7:0] DIGIT_BASE    = 8'd48;
    localparam logic [4:0] DECIMAL_RADIX = 5'd10;

    localparam logic [4:0] WAIT_NONE       = 5'd0;
    localparam logic [4:0] WAIT_INIT_SHORT = 5'd4;
    localparam logic [4:0] WAIT_INIT_LONG  = 5'd20;
    localparam logic [4:0] WAIT_POSITION   = 5'd1;

    localparam logic [2:0] INIT_SHORT_COUNT = 3'd3;
    localparam logic [2:0] INIT_LAST        = 3'd7;

    typedef enum logic [1:0] {
        JOB_INIT = 2'd0,
        JOB_BYTE = 2'd1,
        JOB_NUM  = 2'd2
    } t_job_kind;

    typedef struct packed {
        t_job_kind   kind;
        logic        rs;
        logic [31:0] data;
        logic [4:0]  wait_ms;
    } t_job;

    function automatic logic [7:0] init_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h03;
            3'd1:    b = 8'h03;
            3'd2:    b = 8'h03;
            3'd3:    b = 8'h02;
            3'd4:    b = 8'h28;
            3'd5:    b = 8'h01;
            3'd6:    b = 8'h06;
            3'd7:    b = 8'h0C;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ----- src/char_lcd_nibble_sequencer.sv -----
// top level of the character lcd 4-bit nibble sequencer
//
// Request side: a queue port. A request word (opcode, value, column, row) is
// taken at a clock edge with push high and full low. Unknown opcodes are
// taken and dropped. A two-entry job queue sits behind the classifier.
// Result side: a queue port. While empty is low the oldest nibble word is on
// o_reg_select/o_nibble/o_wait_after_ms/o_last; pop takes it. o_last marks
// the final nibble of a request. The timing of enable strobes and waits is
// left to the consumer.
// The first nibble of a command, char or position request passes the job
// queue, the sequencer state and the result register before it is visible
// when the sequencer is idle; one nibble per cycle follows while pop keeps
// up. Init gives 16 nibbles. A number request first runs a reciprocal-multiply
// divide-by-ten once per decimal digit before its 2 nibbles per digit come out.
// A stalled receiver holds the result register; the sequencer then waits and
// the job queue fills, raising full. Reset empties both queues; no sweep.
module char_lcd_nibble_sequencer #(
    parameter int MAX_DIGITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_opcode,
    input  logic [31:0] i_value,
    input  logic [5:0]  i_x_column,
    input  logic        i_y_row,
    output logic        empty,
    input  logic        pop,
    output logic        o_reg_select,
    output logic [3:0]  o_nibble,
    output logic [4:0]  o_wait_after_ms,
    output logic        o_last
);
    import cln_pkg::*;

    logic w_q_full;
    logic w_front_valid;
    t_job w_front_job;
    logic w_q_not_empty;
    t_job w_q_job;
    logic w_take;

    cln_front u_front (
        .i_push      (push),
        .i_opcode    (i_opcode),
        .i_value     (i_value),
        .i_x_column  (i_x_column),
        .i_y_row     (i_y_row),
        .i_q_full    (w_q_full),
        .o_full      (full),
        .o_job_valid (w_front_valid),
        .o_job       (w_front_job)
    );

    cln_job_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (w_front_valid),
        .i_job       (w_front_job),
        .i_rd        (w_take),
        .o_full      (w_q_full),
        .o_not_empty (w_q_not_empty),
        .o_job       (w_q_job)
    );

    cln_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_valid     (w_q_not_empty),
        .i_job           (w_q_job),
        .o_job_take      (w_take),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_reg_select    (o_reg_select),
        .o_nibble        (o_nibble),
        .o_wait_after_ms (o_wait_after_ms),
        .o_last          (o_last)
    );

endmodule

// ----- src/cln_front.sv -----
// request classifier: turns an accepted request into a job descriptor
module cln_front (
    input  logic          i_push,
    input  logic [2:0]    i_opcode,
    input  logic [31:0]   i_value,
    input  logic [5:0]    i_x_column,
    input  logic          i_y_row,
    input  logic          i_q_full,
    output logic          o_full,
    output logic          o_job_valid,
    output cln_pkg::t_job o_job
);
    import cln_pkg::*;

    logic       w_known;
    logic [7:0] w_pos_byte;

    assign w_pos_byte = (i_y_row ? ROW1_BASE : ROW0_BASE) + {2'b00, i_x_column};

    always_comb begin
        w_known       = 1'b1;
        o_job.kind    = JOB_BYTE;
        o_job.rs      = 1'b0;
        o_job.data    = {24'd0, i_value[7:0]};
        o_job.wait_ms = WAIT_NONE;
        case (i_opcode)
            OP_INIT: begin
                o_job.kind = JOB_INIT;
            end
            OP_COMMAND: begin
                o_job.rs = 1'b0;
            end
            OP_CHAR: begin
                o_job.rs = 1'b1;
            end
            OP_NUMBER: begin
                o_job.kind = JOB_NUM;
                o_job.rs   = 1'b1;
                o_job.data = i_value;
            end
            OP_POSITION: begin
                o_job.data    = {24'd0, w_pos_byte};
                o_job.wait_ms = WAIT_POSITION;
            end
            default: begin
                w_known = 1'b0;
            end
        endcase
    end

    assign o_full      = i_q_full;
    assign o_job_valid = i_push && !i_q_full && w_known;

endmodule

// ----- src/cln_job_queue.sv -----
// two-entry job queue between classifier and sequencer
module cln_job_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  cln_pkg::t_job i_job,
    input  logic          i_rd,
    output logic          o_full,
    output logic          o_not_empty,
    output cln_pkg::t_job o_job
);
    import cln_pkg::*;

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;
    logic       w_wr;
    logic       w_rd;

    assign o_full      = (r_count == 2'd2);
    assign o_not_empty = (r_count != 2'd0);
    assign o_job       = r_mem[r_rd_ptr];
    assign w_wr        = i_wr && !o_full;
    assign w_rd        = i_rd && o_not_empty;

    always_comb begin
        n_wr_ptr = w_wr ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_rd ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (w_wr && !w_rd) begin
            n_count = r_count + 2'd1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ----- src/cln_back.sv -----
// job sequencer: expands jobs into nibble words, with reciprocal divide-by-ten conversion
module cln_back #(
    parameter int MAX_DIGITS = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  cln_pkg::t_job i_job,
    output logic          o_job_take,
    input  logic          i_pop,
    output logic          o_empty,
    output logic          o_reg_select,
    output logic [3:0]    o_nibble,
    output logic [4:0]    o_wait_after_ms,
    output logic          o_last
);
    import cln_pkg::*;

    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_INIT   = 5'b00010,
        S_BYTE   = 5'b00100,
        S_CONV   = 5'b01000,
        S_DIGITS = 5'b10000
    } t_back_state;

    t_back_state r_state, n_state;
    logic [2:0]    r_idx, n_idx;
    logic          r_half, n_half;
    logic [7:0]    r_byte, n_byte;
    logic          r_rs, n_rs;
    logic [4:0]    r_wait, n_wait;
    logic [31:0]   r_val, n_val;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [3:0]    r_digs [MAX_DIGITS];

    logic          r_out_valid, n_out_valid;
    logic          r_out_rs, n_out_rs;
    logic [3:0]    r_out_nib, n_out_nib;
    logic [4:0]    r_out_wait, n_out_wait;
    logic          r_out_last, n_out_last;

    logic          w_slot;
    logic [63:0]   w_prod;
    logic [31:0]   w_quo;
    logic [3:0]    w_q10_lo;
    logic [3:0]    w_rem;
    logic          w_dig_we;
    logic [CW-1:0] w_cnt_dec;
    logic [CW-1:0] w_cnt_inc;
    logic [3:0]    w_dig;
    logic [7:0]    w_char;
    logic [7:0]    w_init;

    // quotient by ten via reciprocal multiply, remainder from the low bits
    assign w_slot     = !r_out_valid || i_pop;
    assign w_prod     = {32'd0, r_val} * {32'd0, DIV10_RECIP};
    assign w_quo      = {3'd0, w_prod[63:35]};
    assign w_q10_lo   = {w_quo[0], 3'b000} + {w_quo[2:0], 1'b0};
    assign w_rem      = r_val[3:0] - w_q10_lo;
    assign w_cnt_dec  = r_cnt - CW'(1);
    assign w_cnt_inc  = r_cnt + CW'(1);
    assign w_dig      = r_digs[w_cnt_dec[IW-1:0]];
    assign w_char     = DIGIT_BASE + {4'd0, w_dig};
    assign w_init     = init_byte(r_idx);
    assign w_dig_we   = (r_state == S_CONV);

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_half      = r_half;
        n_byte      = r_byte;
        n_rs        = r_rs;
        n_wait      = r_wait;
        n_val       = r_val;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_pop;
        n_out_rs    = r_out_rs;
        n_out_nib   = r_out_nib;
        n_out_wait  = r_out_wait;
        n_out_last  = r_out_last;
        o_job_take  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    o_job_take = 1'b1;
                    n_half     = 1'b0;
                    n_idx      = 3'd0;
                    n_byte     = i_job.data[7:0];
                    n_rs       = i_job.rs;
                    n_wait     = i_job.wait_ms;
                    n_val      = i_job.data;
                    n_cnt      = '0;
                    case (i_job.kind)
                        JOB_INIT: n_state = S_INIT;
                        JOB_NUM:  n_state = S_CONV;
                        default:  n_state = S_BYTE;
                    endcase
                end
            end
            S_INIT: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_out_rs    = 1'b0;
                    n_out_nib   = r_half ? w_init[3:0] : w_init[7:4];
                    n_out_wait  = WAIT_NONE;
                    if (r_half && r_idx < INIT_SHORT_COUNT) begin
                        n_out_wait = WAIT_INIT_SHORT;
                    end else if (r_half && r_idx == INIT_LAST) begin
                        n_out_wait = WAIT_INIT_LONG;
                    end
                    n_out_last = r_half && (r_idx == INIT_LAST);
                    n_half     = !r_half;
                    if (r_half) begin
                        n_idx = r_idx + 3'd1;
                        if (r_idx == INIT_LAST) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            S_BYTE: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_out_rs    = r_rs;
                    n_out_nib   = r_half ? r_byte[3:0] : r_byte[7:4];
                    n_out_wait  = r_half ? r_wait : WAIT_NONE;
                    n_out_last  = r_half;
                    n_half      = !r_half;
                    if (r_half) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_CONV: begin
                n_val = w_quo;
                n_cnt = w_cnt_inc;
                if (w_quo == 32'd0 || w_cnt_inc >= CW'(MAX_DIGITS)) begin
                    n_state = S_DIGITS;
                    n_half  = 1'b0;
                end
            end
            S_DIGITS: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_out_rs    = 1'b1;
                    n_out_nib   = r_half ? w_char[3:0] : w_char[7:4];
                    n_out_wait  = WAIT_NONE;
                    n_out_last  = r_half && (r_cnt == CW'(1));
                    n_half      = !r_half;
                    if (r_half) begin
                        n_cnt = w_cnt_dec;
                        if (r_cnt == CW'(1)) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_half     <= n_half;
        r_byte     <= n_byte;
        r_rs       <= n_rs;
        r_wait     <= n_wait;
        r_val      <= n_val;
        r_cnt      <= n_cnt;
        r_out_rs   <= n_out_rs;
        r_out_nib  <= n_out_nib;
        r_out_wait <= n_out_wait;
        r_out_last <= n_out_last;
        if (w_dig_we) begin
            r_digs[r_cnt[IW-1:0]] <= w_rem;
        end
    end

    assign o_empty         = !r_out_valid;
    assign o_reg_select    = r_out_rs;
    assign o_nibble        = r_out_nib;
    assign o_wait_after_ms = r_out_wait;
    assign o_last          = r_out_last;

endmodule

// ----- sim/tb_char_lcd_nibble_sequencer.sv -----
// self-checking testbench for the character lcd nibble sequencer
module tb_char_lcd_nibble_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    import cln_pkg::*;

    localparam int MAX_DIGITS = 10;
    localparam int RANDOM_REQUESTS = 80;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 400;
    localparam int REPORT_LIMIT = 10;

    localparam logic [2:0] OP_SPARE5 = 3'd5;
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;

    localparam logic [7:0] LCD_INIT_SEQ [8] = '{
        8'h03, 8'h03, 8'h03, 8'h02, 8'h28, 8'h01, 8'h06, 8'h0C
    };

    typedef struct packed {
        logic       rs;
        logic [3:0] nib;
        logic [4:0] wait_ms;
        logic       last;
    } t_lcd_word;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] value;
        logic [5:0]  col;
        logic        row;
        logic        typed;
        logic        t_rs;
        logic [7:0]  t_byte;
        logic [4:0]  t_wait;
    } t_request_row;

    localparam int SCRIPT_LEN = 22;

    t_request_row script [SCRIPT_LEN] = '{
        '{OP_INIT,     32'h0000_0000, 6'd0,  1'b0, 1'b0, 1'b0, 8'h00, WAIT_NONE},
        '{OP_COMMAND,  32'h0000_0000, 6'd0,  1'b0, 1'b1, 1'b0, 8'h00, WAIT_NONE},
        '{OP_COMMAND,  32'h0000_00FF, 6'd63, 1'b1, 1'b1, 1'b0, 8'hFF, WAIT_NONE},
        '{OP_COMMAND,  32'hFFFF_FF5A, 6'd0,  1'b0, 1'b0, 1'b0, 8'h00, WAIT_NONE},
        '{OP_CHAR,     32'h0000_0000, 6'd0,  1'b0, 1'b1, 1'b1, 8'h00, WAIT_NONE},
        '{OP_CHAR,     32'hFFFF_FFFF, 6'd63, 1'b1, 1'b1, 1'b1, 8'hFF, WAIT_NONE},
        '{OP_CHAR,     32'h1234_5678, 6'd5,  1'b0, 1'b1, 1'b1, 8'h78, WAIT_NONE},
        '{OP_NUMBER,   32'd0,         6'd0,  1'b0, 1'b1, 1'b1, 8'h30, WAIT_NONE},
        '{OP_NUMBER,   32'd9,         6'd0,  1'b0, 1'b0, 1'b0, 8'h00, WAIT_NONE},
        '{OP_NUMBER,   32'd10,        6'd0,  1'b0, 1'b0, 1'b0, 8'h00, WAIT_NONE},
        '{OP_NUMBER,   32'hFFFF_FFFF, 6'd63, 1'b1, 1'b0, 1'b0, 8'h00, WAIT_NONE},
        '{OP_NUMBER,   32'd1000000000, 6'd0, 1'b0, 1'b0, 1'b0, 8'h00, WAIT_NONE},
        '{OP_NUMBER,   32'hAAAA_5555, 6'd0,  1'b0, 1'b0, 1'b0, 8'h00, WAIT_NONE},
        '{OP_POSITION, 32'h0000_0000, 6'd0,  1'b0, 1'b1, 1'b0, 8'h80, WAIT_POSITION},
        '{OP_POSITION, 32'h0000_0000, 6'd63, 1'b0, 1'b1, 1'b0, 8'hBF, WAIT_POSITION},
        '{OP_POSITION, 32'hFFFF_FFFF, 6'd0,  1'b1, 1'b1, 1'b0, 8'hC0, WAIT_POSITION},
        '{OP_POSITION, 32'h0000_0000, 6'd63, 1'b1, 1'b1, 1'b0, 8'hFF, WAIT_POSITION},
        '{OP_POSITION, 32'hFFFF_FFFF, 6'd21, 1'b1, 1'b0, 1'b0, 8'h00, WAIT_NONE},
        '{OP_SPARE5,   32'hFFFF_FFFF, 6'd63, 1'b1, 1'b0, 1'b0, 8'h00, WAIT_NONE},
        '{OP_SPARE6,   32'h0000_0000, 6'd0,  1'b0, 1'b0, 1'b0, 8'h00, WAIT_NONE},
        '{OP_SPARE7,   32'h5A5A_A5A5, 6'd42, 1'b1, 1'b0, 1'b0, 8'h00, WAIT_NONE},
        '{OP_INIT,     32'hFFFF_FFFF, 6'd63, 1'b1, 1'b0, 1'b0, 8'h00, WAIT_NONE}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [2:0]  i_opcode = OP_INIT;
    logic [31:0] i_value = '0;
    logic [5:0]  i_x_column = '0;
    logic        i_y_row = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic        o_reg_select;
    logic [3:0]  o_nibble;
    logic [4:0]  o_wait_after_ms;
    logic        o_last;

    logic calm = 1'b0;
    logic hold = 1'b0;
    logic hold_req = 1'b0;
    int   fails = 0;

    t_lcd_word lcd_words_due [$];
    t_lcd_word got_w;
    t_lcd_word exp_w;

    char_lcd_nibble_sequencer #(
        .MAX_DIGITS(MAX_DIGITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_opcode       (i_opcode),
        .i_value        (i_value),
        .i_x_column     (i_x_column),
        .i_y_row        (i_y_row),
        .empty          (empty),
        .pop            (pop),
        .o_reg_select   (o_reg_select),
        .o_nibble       (o_nibble),
        .o_wait_after_ms(o_wait_after_ms),
        .o_last         (o_last)
    );

    always #5 i_clk = ~i_clk;

    function automatic void add_byte(input logic rs, input logic [7:0] b,
                                     input logic [4:0] w);
        lcd_words_due.push_back(t_lcd_word'{rs, b[7:4], WAIT_NONE, 1'b0});
        lcd_words_due.push_back(t_lcd_word'{rs, b[3:0], w, 1'b0});
    endfunction

    function automatic void mark_last(input int start_size);
        if (lcd_words_due.size() > start_size) begin
            lcd_words_due[lcd_words_due.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic void predict_lcd_words(input logic [2:0] op, input logic [31:0] value,
                                              input logic [5:0] col, input logic row);
        logic [7:0]  digits [MAX_DIGITS];
        logic [31:0] rest;
        logic [7:0]  addr;
        int          n;
        int          start_size;
        start_size = lcd_words_due.size();
        case (op)
            OP_INIT: begin
                for (int i = 0; i < 8; i++) begin
                    add_byte(1'b0, LCD_INIT_SEQ[i],
                             (i < 3) ? WAIT_INIT_SHORT : ((i == 7) ? WAIT_INIT_LONG : WAIT_NONE));
                end
            end
            OP_COMMAND: begin
                add_byte(1'b0, value[7:0], WAIT_NONE);
            end
            OP_CHAR: begin
                add_byte(1'b1, value[7:0], WAIT_NONE);
            end
            OP_NUMBER: begin
                rest = value;
                n = 0;
                do begin
                    digits[n] = DIGIT_BASE + 8'(rest % 32'(DECIMAL_RADIX));
                    rest = rest / 32'(DECIMAL_RADIX);
                    n++;
                end while (rest != 0 && n < MAX_DIGITS);
                for (int i = n - 1; i >= 0; i--) begin
                    add_byte(1'b1, digits[i], WAIT_NONE);
                end
            end
            OP_POSITION: begin
                addr = (row ? ROW1_BASE : ROW0_BASE) + {2'b00, col};
                add_byte(1'b0, addr, WAIT_POSITION);
            end
            default: begin
            end
        endcase
        mark_last(start_size);
    endfunction

    task automatic offer_request(input t_request_row req);
        int start_size;
        while (!calm && $urandom_range(0, 99) < 10) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push       <= 1'b1;
        i_opcode   <= req.op;
        i_value    <= req.value;
        i_x_column <= req.col;
        i_y_row    <= req.row;
        do @(posedge i_clk); while (full);
        if (req.typed) begin
            start_size = lcd_words_due.size();
            add_byte(req.t_rs, req.t_byte, req.t_wait);
            mark_last(start_size);
        end else begin
            predict_lcd_words(req.op, req.value, req.col, req.row);
        end
    endtask

    // result side: random pop, long hold-off on request
    always @(posedge i_clk) begin
        pop <= !hold && (calm || $urandom_range(0, 99) >= 10);
    end

    initial begin
        wait (hold_req);
        @(posedge i_clk);
        hold <= 1'b1;
        for (int k = 0; k < HOLD_CYCLES; k++) begin
            @(posedge i_clk);
        end
        hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            got_w = '{o_reg_select, o_nibble, o_wait_after_ms, o_last};
            if (lcd_words_due.size() == 0) begin
                if (fails < REPORT_LIMIT) begin
                    $display("unexpected word rs=%b nib=%h wait=%0d last=%b",
                             got_w.rs, got_w.nib, got_w.wait_ms, got_w.last);
                end
                fails++;
            end else begin
                exp_w = lcd_words_due.pop_front();
                if (got_w != exp_w) begin
                    if (fails < REPORT_LIMIT) begin
                        $display({"mismatch: expected rs=%b nib=%h wait=%0d last=%b,",
                                  " got rs=%b nib=%h wait=%0d last=%b"},
                                 exp_w.rs, exp_w.nib, exp_w.wait_ms, exp_w.last,
                                 got_w.rs, got_w.nib, got_w.wait_ms, got_w.last);
                    end
                    fails++;
                end
            end
        end
    end

    initial begin
        t_request_row req;
        int           real_cnt;
        int           pick;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < SCRIPT_LEN; r++) begin
            offer_request(script[r]);
        end

        real_cnt = 0;
        while (real_cnt < RANDOM_REQUESTS) begin
            pick = $urandom_range(0, 99);
            req = '0;
            if (pick < 8) begin
                req.op = OP_INIT;
            end else if (pick < 28) begin
                req.op = OP_COMMAND;
            end else if (pick < 50) begin
                req.op = OP_CHAR;
            end else if (pick < 75) begin
                req.op = OP_NUMBER;
            end else if (pick < 92) begin
                req.op = OP_POSITION;
            end else begin
                req.op = 3'($urandom_range(OP_SPARE5, OP_SPARE7));
            end
            req.value = $urandom;
            if (req.op == OP_NUMBER && $urandom_range(0, 1) == 1) begin
                req.value = req.value >> $urandom_range(0, 31);
            end
            req.col = 6'($urandom_range(0, 63));
            req.row = 1'($urandom_range(0, 1));
            if (real_cnt == 20) begin
                hold_req <= 1'b1;
            end
            calm <= (real_cnt >= 40 && real_cnt < 70);
            offer_request(req);
            if (req.op <= OP_POSITION) begin
                real_cnt++;
            end
        end
        push <= 1'b0;
        calm <= 1'b0;

        while (lcd_words_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (lcd_words_due.size() != 0) begin
            $display("%0d words never arrived", lcd_words_due.size());
            fails++;
        end
        if (fails == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

endmodule
